// ----- rtl/time_of_week_histogram_core_assert.svh -----
// Assertion macros for the time-of-week histogram core.
// Included by the top level; depends on nothing else.
`ifndef TIME_OF_WEEK_HISTOGRAM_CORE_ASSERT_SVH
`define TIME_OF_WEEK_HISTOGRAM_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TOW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tow_pkg.sv -----
// Shared types and constants for the time-of-week histogram core.
// No dependencies; tow_div and the top level import this package.
`default_nettype none

package tow_pkg;

    localparam int NUM_BINS_DEF   = 256;
    localparam int COUNT_BITS_DEF = 32;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;

    localparam logic [31:0] RESET_PERIOD = 32'(60 * 60 * 24 * 7);
    localparam logic [31:0] RESET_BIN    = 32'(60 * 60);
    localparam logic [31:0] RESET_OFFSET = 32'(4 * 24 * 60 * 60);

    localparam logic [31:0] NS_PER_SEC = 32'd1000000000;

    // One billion is 2^9 * 1953125. Seconds are estimated by shifting the count right
    // by 9 and multiplying its top 32 bits by floor(2^52 / 1953125); the estimate is at
    // most 7 low and is then fixed by comparing the remainder against small multiples.
    localparam int          SEC_SHIFT = 9;
    localparam logic [20:0] SEC_DIV   = 21'(NS_PER_SEC >> SEC_SHIFT);
    localparam logic [31:0] SEC_RECIP = 32'((64'd1 << 52) / 64'(SEC_DIV));

    // Request types.
    localparam logic REQ_COUNT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_COUNTED = 2'd0;
    localparam logic [1:0] ST_SKIPPED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_READ    = 2'd3;

    // The divider produces 34 quotient bits: enough for the offset-corrected seconds
    // of a 63-bit nanosecond count.
    localparam int DIV_STEPS = 34;
    localparam int DIV_Q_W   = 34;
    localparam int DIV_R_W   = 32;

    typedef struct packed {
        logic                req_type;
        logic [62:0]         timestamp_ns;
        logic                timestamp_valid;
        logic [7:0]          read_bin;
    } tow_in_t;

    typedef struct packed {
        logic [7:0]          bin_index;
        logic [31:0]         bin_count;
        logic [1:0]          status;
    } tow_out_t;

    typedef struct packed {
        logic                start;
        logic [DIV_Q_W-1:0]  dividend;
        logic [DIV_R_W-1:0]  divisor;
    } tow_div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_Q_W-1:0]  quotient;
        logic [DIV_R_W-1:0]  remainder;
    } tow_div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/tow_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// The payload type is supplied at instantiation, normally from tow_pkg.
`default_nettype none

interface tow_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/tow_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, DIV_STEPS steps.
// Uses the request and response structs of tow_pkg.
`default_nettype none

module tow_div (
    input  wire                   clk,
    input  wire                   rst_n,
    input  tow_pkg::tow_div_req_t req,
    output tow_pkg::tow_div_rsp_t rsp
);
    import tow_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_R_W-1:0] rem_reg, rem_next;
    logic [DIV_Q_W-1:0] quo_reg, quo_next;
    logic [DIV_R_W-1:0] dvs_reg, dvs_next;

    logic [DIV_R_W:0]   trial;
    logic [DIV_R_W:0]   diff;
    logic               fits;

    // The dividend bits shift out of the top of quo_reg while the quotient
    // bits shift in at the bottom.
    assign trial = {rem_reg, quo_reg[DIV_Q_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_R_W-1:0] : trial[DIV_R_W-1:0];
            quo_next = {quo_reg[DIV_Q_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/time_of_week_histogram_core.sv -----
// Time-of-week histogram: a count item passes through reciprocal seconds conversion, two
// divider passes, a bin check, a counter read and a write back before its result is loaded.
// Reads go through a counter read; skipped items, out-of-range reads and other drops go
// to the result directly. The next transfer is taken the cycle after a result is loaded,
// so no new item is taken before the last is through. After reset the bin memory is swept to zero with input ready low.
// Depends on tow_pkg, tow_stream_if, tow_div and the assertion macro header.
`default_nettype none
`include "time_of_week_histogram_core_assert.svh"

module time_of_week_histogram_core #(
    parameter int NUM_BINS   = tow_pkg::NUM_BINS_DEF,
    parameter int COUNT_BITS = tow_pkg::COUNT_BITS_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_we,
    input  wire [tow_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [tow_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    tow_stream_if.sink                     in_ch,
    tow_stream_if.source                   out_ch
);
    import tow_pkg::*;

    localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SEC_MUL  = 4'd2;
    localparam logic [3:0] S_SEC_BACK = 4'd3;
    localparam logic [3:0] S_SEC_REM  = 4'd4;
    localparam logic [3:0] S_SEC_FIX  = 4'd5;
    localparam logic [3:0] S_SEC_CHK  = 4'd6;
    localparam logic [3:0] S_DIV_MOD  = 4'd7;
    localparam logic [3:0] S_DIV_BIN  = 4'd8;
    localparam logic [3:0] S_CHECK    = 4'd9;
    localparam logic [3:0] S_MEM_RD   = 4'd10;
    localparam logic [3:0] S_EMIT     = 4'd11;

    logic [3:0]            state_reg, state_next;
    logic [31:0]           period_reg, period_next;
    logic [31:0]           binw_reg, binw_next;
    logic [31:0]           offset_reg, offset_next;
    logic [IDX_W-1:0]      clr_reg, clr_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  req_reg, req_next;
    logic [IDX_W-1:0]      bin_reg, bin_next;
    logic [48:0]           prod_reg, prod_next;
    logic [7:0]            res_idx_reg, res_idx_next;
    logic [31:0]           res_cnt_reg, res_cnt_next;
    logic [1:0]            res_st_reg, res_st_next;
    tow_out_t              out_data_reg, out_data_next;
    logic [COUNT_BITS-1:0] rdata_reg;

    logic [53:0]           sec_x_reg, sec_x_next;
    logic [63:0]           sec_est_reg, sec_est_next;
    logic [54:0]           sec_back_reg, sec_back_next;
    logic [23:0]           sec_rem_reg, sec_rem_next;
    logic [DIV_Q_W-1:0]    secs_reg, secs_next;

    logic [COUNT_BITS-1:0] mem [NUM_BINS];
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;

    tow_div_req_t          div_req;
    tow_div_rsp_t          div_rsp;

    logic                  in_xfer;
    logic [31:0]           rbin_ext;
    logic [DIV_Q_W-1:0]    offset_ext;
    logic [16:0]           bin_p1;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [DIV_Q_W-1:0]    sec_q;
    logic [2:0]            sec_corr;

    tow_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign in_xfer        = in_ch.valid && in_ch.ready;
    assign rbin_ext       = 32'(in_ch.payload.read_bin);
    assign offset_ext     = DIV_Q_W'(offset_reg);
    assign bin_p1         = div_rsp.quotient[16:0] + 17'd1;
    // Saturating increment of the counter just read.
    assign new_cnt        = (&rdata_reg) ? rdata_reg : rdata_reg + COUNT_BITS'(1);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_data_reg;
    assign sec_q          = DIV_Q_W'(sec_est_reg[63:30]);

    // The thresholds ascend, so the last one passed gives the number of divisors
    // still left in the remainder.
    always_comb
    begin
        sec_corr = '0;
        for (int k = 1; k < 8; k++)
        begin
            if (sec_rem_reg >= 24'(k * int'(SEC_DIV)))
            begin
                sec_corr = 3'(k);
            end
        end
    end

    always_comb
    begin
        period_next = period_reg;
        binw_next   = binw_reg;
        offset_next = offset_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PERIOD: period_next = cfg_wdata;
                REG_BIN:    binw_next   = cfg_wdata;
                REG_OFFSET: offset_next = cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        req_next       = req_reg;
        bin_next       = bin_reg;
        prod_next      = prod_reg;
        res_idx_next   = res_idx_reg;
        res_cnt_next   = res_cnt_reg;
        res_st_next    = res_st_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        sec_x_next     = sec_x_reg;
        sec_est_next   = sec_est_reg;
        sec_back_next  = sec_back_reg;
        sec_rem_next   = sec_rem_reg;
        secs_next      = secs_reg;
        mem_we         = 1'b0;
        mem_waddr      = bin_reg;
        mem_wdata      = new_cnt;
        mem_re         = 1'b0;
        mem_raddr      = bin_reg;
        div_req        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(NUM_BINS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    req_next = in_ch.payload.req_type;
                    if (in_ch.payload.req_type == REQ_READ)
                    begin
                        res_idx_next = in_ch.payload.read_bin;
                        if (rbin_ext >= 32'(NUM_BINS))
                        begin
                            res_cnt_next = '0;
                            res_st_next  = ST_DROPPED;
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            mem_re      = 1'b1;
                            mem_raddr   = rbin_ext[IDX_W-1:0];
                            res_st_next = ST_READ;
                            state_next  = S_MEM_RD;
                        end
                    end
                    else if (!in_ch.payload.timestamp_valid)
                    begin
                        res_idx_next = '0;
                        res_cnt_next = '0;
                        res_st_next  = ST_SKIPPED;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        sec_x_next = in_ch.payload.timestamp_ns[62:SEC_SHIFT];
                        state_next = S_SEC_MUL;
                    end
                end
            end
            S_SEC_MUL:
            begin
                sec_est_next = 64'(sec_x_reg[53:22]) * 64'(SEC_RECIP);
                state_next   = S_SEC_BACK;
            end
            S_SEC_BACK:
            begin
                sec_back_next = 55'(sec_q) * 55'(SEC_DIV);
                state_next    = S_SEC_REM;
            end
            S_SEC_REM:
            begin
                // The estimate is never high, so the remainder is below eight divisors.
                sec_rem_next = 24'(55'(sec_x_reg) - sec_back_reg);
                state_next   = S_SEC_FIX;
            end
            S_SEC_FIX:
            begin
                secs_next  = sec_q + DIV_Q_W'(sec_corr);
                state_next = S_SEC_CHK;
            end
            S_SEC_CHK:
            begin
                if (secs_reg < offset_ext || period_reg == '0 || binw_reg == '0)
                begin
                    res_idx_next = '0;
                    res_cnt_next = '0;
                    res_st_next  = ST_DROPPED;
                    state_next   = S_EMIT;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = secs_reg - offset_ext;
                    div_req.divisor  = period_reg;
                    state_next       = S_DIV_MOD;
                end
            end
            S_DIV_MOD:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_Q_W'(div_rsp.remainder);
                    div_req.divisor  = binw_reg;
                    state_next       = S_DIV_BIN;
                end
            end
            S_DIV_BIN:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient >= DIV_Q_W'(NUM_BINS))
                    begin
                        res_idx_next = '0;
                        res_cnt_next = '0;
                        res_st_next  = ST_DROPPED;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        bin_next     = div_rsp.quotient[IDX_W-1:0];
                        res_idx_next = div_rsp.quotient[7:0];
                        // bin < period / bin_secs exactly when (bin + 1) * bin_secs <= period.
                        prod_next    = 49'(bin_p1) * 49'(binw_reg);
                        state_next   = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (prod_reg > 49'(period_reg))
                begin
                    res_idx_next = '0;
                    res_cnt_next = '0;
                    res_st_next  = ST_DROPPED;
                    state_next   = S_EMIT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = bin_reg;
                    state_next = S_MEM_RD;
                end
            end
            S_MEM_RD:
            begin
                if (req_reg == REQ_COUNT)
                begin
                    mem_we       = 1'b1;
                    res_cnt_next = 32'(new_cnt);
                    res_st_next  = ST_COUNTED;
                end
                else
                begin
                    res_cnt_next = 32'(rdata_reg);
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.bin_index = res_idx_reg;
                    out_data_next.bin_count = res_cnt_reg;
                    out_data_next.status    = res_st_reg;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            period_reg    <= RESET_PERIOD;
            binw_reg      <= RESET_BIN;
            offset_reg    <= RESET_OFFSET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            period_reg    <= period_next;
            binw_reg      <= binw_next;
            offset_reg    <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        bin_reg      <= bin_next;
        prod_reg     <= prod_next;
        res_idx_reg  <= res_idx_next;
        res_cnt_reg  <= res_cnt_next;
        res_st_reg   <= res_st_next;
        out_data_reg <= out_data_next;
        sec_x_reg    <= sec_x_next;
        sec_est_reg  <= sec_est_next;
        sec_back_reg <= sec_back_next;
        sec_rem_reg  <= sec_rem_next;
        secs_reg     <= secs_next;
    end

    // Bin counter memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    `TOW_ASSERT_NEXT(a_xfer_leaves_idle, clk, rst_n, in_xfer, (state_reg != S_IDLE),
                     "item transfer did not leave idle")
    `TOW_ASSERT_SAME(a_div_done_in_div, clk, rst_n, div_rsp.done,
                     (state_reg == S_DIV_MOD || state_reg == S_DIV_BIN),
                     "divider finished outside a divide state")
    `TOW_ASSERT_SAME(a_count_update, clk, rst_n, (mem_we && state_reg == S_MEM_RD),
                     (mem_wdata == rdata_reg + COUNT_BITS'(1) || ((&rdata_reg) && mem_wdata == rdata_reg)),
                     "counter write is not a saturating increment")

endmodule

`default_nettype wire

// ----- tb/sv/tow_tb_pkg.sv -----
`timescale 1ns / 1ps
// Bin tracker for the time-of-week histogram testbench: predicts each result and checks it.
// Depends on tow_pkg for the request, result and register codes.
package tow_tb_pkg;
    import tow_pkg::*;

    // The port has room for one index past the register list; writes there are ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    class tow_bin_tracker;
        logic [31:0] period_secs;
        logic [31:0] bin_secs;
        logic [31:0] offset_secs;
        logic [31:0] bin_tally [NUM_BINS_DEF];
        tow_out_t    awaited_results [$];
        int          fail_count;

        function new();
            period_secs = RESET_PERIOD;
            bin_secs    = RESET_BIN;
            offset_secs = RESET_OFFSET;
            foreach (bin_tally[i])
            begin
                bin_tally[i] = '0;
            end
            fail_count = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_PERIOD: period_secs = val;
                REG_BIN:    bin_secs    = val;
                REG_OFFSET: offset_secs = val;
                default:    ;
            endcase
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // Folds one accepted request into the bin tally and queues the result it must produce.
        function void note_request(tow_in_t req);
            tow_out_t    res;
            logic [63:0] secs;
            logic [63:0] folded;
            logic [63:0] bin_no;
            logic [63:0] limit;
            res = '0;
            if (req.req_type == REQ_READ)
            begin
                res.bin_index = req.read_bin;
                if (int'(req.read_bin) >= NUM_BINS_DEF)
                begin
                    res.status = ST_DROPPED;
                end
                else
                begin
                    res.bin_count = bin_tally[req.read_bin];
                    res.status    = ST_READ;
                end
            end
            else if (!req.timestamp_valid)
            begin
                res.status = ST_SKIPPED;
            end
            else
            begin
                secs = {1'b0, req.timestamp_ns} / 64'(NS_PER_SEC);
                res.status = ST_DROPPED;
                if (secs >= 64'(offset_secs) && period_secs != 0 && bin_secs != 0)
                begin
                    folded = (secs - 64'(offset_secs)) % 64'(period_secs);
                    bin_no = folded / 64'(bin_secs);
                    limit  = 64'(period_secs) / 64'(bin_secs);
                    // A period that is not a multiple of the bin width leaves a short
                    // last bin, which is dropped rather than counted.
                    if (bin_no < limit && bin_no < 64'(NUM_BINS_DEF))
                    begin
                        if (bin_tally[bin_no[7:0]] != '1)
                        begin
                            bin_tally[bin_no[7:0]] = bin_tally[bin_no[7:0]] + 1;
                        end
                        res.bin_index = bin_no[7:0];
                        res.bin_count = bin_tally[bin_no[7:0]];
                        res.status    = ST_COUNTED;
                    end
                end
            end
            awaited_results.push_back(res);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(tow_out_t got);
            tow_out_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result with nothing outstanding: bin_index %0d bin_count %0d status %0d",
                       got.bin_index, got.bin_count, got.status);
                fail_count++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("bin_index", 32'(want.bin_index), 32'(got.bin_index));
            compare_field("bin_count", want.bin_count, got.bin_count);
            compare_field("status", 32'(want.status), 32'(got.status));
        endfunction
    endclass

endpackage

// ----- tb/sv/time_of_week_histogram_core_tb.sv -----
`timescale 1ns / 1ps
// Top of the time-of-week histogram testbench: clock, reset, stimulus and the receiver.
// Depends on tow_pkg, tow_stream_if, tow_tb_pkg and the time_of_week_histogram_core RTL.
module time_of_week_histogram_core_tb;
    import tow_pkg::*;
    import tow_tb_pkg::*;

    localparam logic [63:0] MAX_TS       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX_SECS     = MAX_TS / 64'd1000000000;
    localparam int          PHASE_ITEMS  = 100;
    localparam int          DRAIN_CYCLES = 150;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  sink_ready = 1'b0;
    int unsigned           ready_hold = 0;

    tow_bin_tracker tracker;

    tow_stream_if #(.payload_t(tow_in_t))  in_ch ();
    tow_stream_if #(.payload_t(tow_out_t)) out_ch ();

    assign out_ch.ready = sink_ready;

    time_of_week_histogram_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: short random stalls, with an occasional long stretch of steady ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
            ready_hold <= 0;
        end
        else if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            sink_ready <= 1'b1;
            ready_hold <= $urandom_range(100, 400);
        end
        else
        begin
            sink_ready <= ($urandom_range(0, 2) != 0);
            ready_hold <= $urandom_range(0, 20);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                tracker.note_request(in_ch.payload);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                tracker.check_result(out_ch.payload);
            end
        end
    end

    // Holds the request until the transfer; valid stays high for a following request.
    task automatic send_request(input tow_in_t req);
        in_ch.valid   <= 1'b1;
        in_ch.payload <= req;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_gap(input int unsigned cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        tracker.set_register(idx, val);
    endtask

    task automatic apply_setting(input logic [31:0] period, input logic [31:0] bin_width,
                                 input logic [31:0] offset);
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_PERIOD, period);
        write_reg(REG_BIN, bin_width);
        write_reg(REG_OFFSET, offset);
        cfg_we <= 1'b0;
    endtask

    // Stops sending and waits until every outstanding result has been taken.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [62:0] stamp_at(input logic [63:0] secs);
        logic [63:0] ns;
        ns = secs * 64'(NS_PER_SEC) + 64'($urandom_range(0, 999999999));
        if (ns > MAX_TS)
        begin
            ns = MAX_TS;
        end
        return ns[62:0];
    endfunction

    // Picks whole seconds that land on a chosen bin of the current setting, sometimes on
    // the short last bin or up to two bins past the store, a few periods past the offset.
    function automatic logic [63:0] target_secs();
        logic [63:0] per;
        logic [63:0] bw;
        logic [63:0] nb;
        logic [63:0] folded;
        logic [63:0] secs;
        int unsigned pick;
        per = 64'(tracker.period_secs);
        bw  = 64'(tracker.bin_secs);
        if (per == 0 || bw == 0)
        begin
            folded = 64'($urandom);
        end
        else
        begin
            nb = per / bw;
            pick = (nb > 257) ? $urandom_range(0, 257) : $urandom_range(0, 32'(nb));
            folded = 64'(pick) * bw + 64'($urandom) % bw;
            if (folded >= per)
            begin
                folded = {$urandom, $urandom} % per;
            end
        end
        secs = 64'(tracker.offset_secs) + folded + per * 64'($urandom_range(0, 3));
        if (secs > MAX_SECS)
        begin
            secs = 64'(tracker.offset_secs) + folded;
        end
        return secs;
    endfunction

    function automatic tow_in_t count_item(input logic [63:0] ts);
        tow_in_t req;
        req.req_type        = REQ_COUNT;
        req.timestamp_ns    = ts[62:0];
        req.timestamp_valid = 1'b1;
        req.read_bin        = 8'($urandom);
        return req;
    endfunction

    function automatic tow_in_t read_item(input logic [7:0] bin_no, input logic valid_bit);
        tow_in_t req;
        req.req_type        = REQ_READ;
        req.timestamp_ns    = 63'({$urandom, $urandom});
        req.timestamp_valid = valid_bit;
        req.read_bin        = bin_no;
        return req;
    endfunction

    function automatic tow_in_t random_request();
        tow_in_t     req;
        int unsigned kind;
        kind = $urandom_range(0, 99);
        req = count_item({$urandom, $urandom});
        if (kind < 65)
        begin
            req.timestamp_ns = stamp_at(target_secs());
        end
        else if (kind < 75)
        begin
            req.timestamp_valid = 1'b0;
        end
        else if (kind < 88)
        begin
            req = read_item(8'($urandom), 1'($urandom));
            if ($urandom_range(0, 1) == 1)
            begin
                req.read_bin = 8'($urandom_range(0, 31));
            end
        end
        return req;
    endfunction

    // Boundaries under the power-on setting: around the offset, the last bin of the week,
    // the largest timestamp, skipped items and reads.
    task automatic run_directed();
        logic [63:0] base;
        tow_in_t     req;
        base = 64'(RESET_OFFSET) * 64'(NS_PER_SEC);
        send_request(count_item(64'd0));
        send_request(count_item(base - 64'd1));
        send_request(count_item(base));
        send_request(count_item(base + (64'(RESET_PERIOD) - 64'd1) * 64'(NS_PER_SEC)
                                + 64'd999999999));
        send_request(count_item(base + 64'(RESET_PERIOD) * 64'(NS_PER_SEC)));
        send_request(count_item(MAX_TS));
        for (int k = 0; k < 3; k++)
        begin
            send_request(count_item(base + (64'(5) * 64'(RESET_BIN) + 64'(k))
                                    * 64'(NS_PER_SEC)));
        end
        req = count_item(MAX_TS);
        req.timestamp_valid = 1'b0;
        req.read_bin = 8'hFF;
        send_request(req);
        req = count_item(64'd0);
        req.timestamp_valid = 1'b0;
        req.read_bin = 8'h00;
        send_request(req);
        send_request(read_item(8'd0, 1'b1));
        send_request(read_item(8'd5, 1'b0));
        send_request(read_item(8'd167, 1'b1));
        send_request(read_item(8'd168, 1'b0));
        send_request(read_item(8'd255, 1'b1));
        req = read_item(8'd5, 1'b1);
        req.timestamp_ns = '1;
        send_request(req);
    endtask

    task automatic run_random(input int count);
        int unsigned burst_left;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                idle_gap(($urandom_range(0, 3) == 0) ? $urandom_range(1, 130)
                                                     : $urandom_range(1, 12));
                burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
            end
            send_request(random_request());
            burst_left--;
        end
    endtask

    task automatic run_phase(input logic [31:0] period, input logic [31:0] bin_width,
                             input logic [31:0] offset);
        settle();
        apply_setting(period, bin_width, offset);
        run_random(PHASE_ITEMS);
    endtask

    initial
    begin
        logic [31:0] span;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_PERIOD;
        cfg_wdata     = '0;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(PHASE_ITEMS);
        run_phase(32'd86400, 32'd3600, 32'd0);
        run_phase(32'd100, 32'd7, $urandom);
        run_phase(32'd1, 32'd1, 32'hFFFF_FFFF);
        run_phase(32'd0, 32'd3600, 32'd1000);
        run_phase(RESET_PERIOD, 32'd0, RESET_OFFSET);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(32'd15360, 32'd60, $urandom_range(0, 1000000));
        run_phase(32'd10000, 32'd10, 32'd12345);
        run_phase(32'd5, 32'd10, 32'd0);
        span = $urandom_range(1, 1 << 20);
        run_phase(span, $urandom_range(1, span), $urandom);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.fail_count == 0)
        begin
            $display("time_of_week_histogram_core_tb OK");
        end
        else
        begin
            $display("time_of_week_histogram_core_tb NOT OK");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("time_of_week_histogram_core_tb NOT OK");
        $finish;
    end

endmodule
